### rtl/lots_pkg.sv
// Shared constants and cell control type for the letter-order topological sort.
package lots_pkg;

  localparam int unsigned NodeCountDef = 26;
  localparam int unsigned LetterW      = 5;

  typedef struct packed {
    logic rot;      // rotate rows one cell toward cell 0
    logic clr;      // clear row
    logic deg_clr;  // clear in-degree
  } lots_ctrl_t;

endpackage

### rtl/lots_cell.sv
// One node cell: holds its adjacency row and its in-degree counter.
module lots_cell #(
  parameter int unsigned NODE_COUNT = lots_pkg::NodeCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lots_pkg::lots_ctrl_t          ctrl_i,
  input  logic                          set_i,
  input  logic [NODE_COUNT-1:0]         set_col_i,
  input  logic [NODE_COUNT-1:0]         row_i,
  input  logic                          inc_i,
  input  logic                          dec_i,
  output logic [NODE_COUNT-1:0]         row_o,
  output logic [$clog2(NODE_COUNT)-1:0] deg_o
);
  import lots_pkg::*;

  localparam int unsigned DW = $clog2(NODE_COUNT);

  logic [NODE_COUNT-1:0] row_q, row_d;
  logic [DW-1:0]         deg_q, deg_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.clr) begin
      row_d = '0;
    end else if (ctrl_i.rot) begin
      row_d = row_i;
    end else if (set_i) begin
      row_d = row_q | set_col_i;
    end
    deg_d = deg_q;
    if (ctrl_i.deg_clr) begin
      deg_d = '0;
    end else if (inc_i) begin
      deg_d = deg_q + DW'(1);
    end else if (dec_i) begin
      deg_d = deg_q - DW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= deg_d;
  end

  assign row_o = row_q;
  assign deg_o = deg_q;

endmodule

### rtl/letter_order_topological_sort_core.sv
// Top level: letter stream to adjacency cells, Kahn sort sequencer, result register.
//
// Input channel (in_valid_i / in_stall_o): words of op, letter and starts_word.
// A letter word sets at most one edge bit in the row of the previous letter. A
// finish word starts the sort; in_stall_o stays high until the last result of
// the run has been loaded into the output register.
// Output channel (out_valid_o / out_stall_i): one word per ordered node, the
// final one with last_o set and acyclic_o telling whether every node was
// ordered; with no orderable node a single word with node_valid_o low.
// Sort steps: the rows rotate once around the cell chain to count in-degrees,
// every node of in-degree zero is seeded into the queue, then per ordered node
// come a queue read, a scan of its row one column per cycle and an emit
// step; the per-column scan of each popped row dominates the sort time. A stall
// on the output holds the emit step and so the sequencer. Reset (rst_ni,
// asynchronous) clears the matrix, word tracking and handshake state; the
// matrix is also cleared after every finish.
module letter_order_topological_sort_core #(
  parameter int unsigned NODE_COUNT = lots_pkg::NodeCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [lots_pkg::LetterW-1:0] letter_i,
  input  logic                        starts_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lots_pkg::LetterW-1:0] node_o,
  output logic                        node_valid_o,
  output logic                        last_o,
  output logic                        acyclic_o
);
  import lots_pkg::*;

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned CW = IW + 1;

  typedef enum logic [2:0] {
    StIdle, StCount, StSeed, StPop, StScan, StEmit, StEmpty
  } state_e;

  state_e            state_q;
  logic [IW-1:0]     cnt_q;
  logic [CW-1:0]     head_q, tail_q;
  logic [LetterW-1:0] prev_q;
  logic              prev_valid_q;
  logic [IW-1:0]     rd_q;
  logic [IW-1:0]     q_mem [NODE_COUNT];

  logic              out_valid_q, node_valid_q, last_q, acyclic_q;
  logic [LetterW-1:0] node_q;

  logic [NODE_COUNT-1:0] rows_w [NODE_COUNT];
  logic [IW-1:0]         deg_w  [NODE_COUNT];
  logic [NODE_COUNT-1:0] set_col, dec_vec;
  lots_ctrl_t            ctrl;

  logic in_acc, letter_ok, set_en, out_free, scan_bit, push;
  logic [IW-1:0] push_idx;
  logic cnt_end;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign letter_ok  = (32'(letter_i) < 32'(NODE_COUNT));
  assign set_en     = in_acc && !op_i && letter_ok && !starts_word_i && prev_valid_q
                      && (prev_q != letter_i);
  assign set_col    = NODE_COUNT'(1) << letter_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_end    = (32'(cnt_q) == NODE_COUNT - 1);
  assign scan_bit   = rows_w[rd_q][cnt_q];
  assign dec_vec    = (state_q == StScan && scan_bit) ? (NODE_COUNT'(1) << cnt_q) : '0;

  always_comb begin
    ctrl.rot     = (state_q == StCount);
    ctrl.clr     = 1'b0;
    ctrl.deg_clr = in_acc && op_i;
    if (state_q == StEmpty && out_free) ctrl.clr = 1'b1;
    if (state_q == StEmit && out_free && head_q == tail_q) ctrl.clr = 1'b1;
    push     = 1'b0;
    push_idx = cnt_q;
    if (state_q == StSeed && deg_w[cnt_q] == '0) push = 1'b1;
    if (state_q == StScan && scan_bit && deg_w[cnt_q] == IW'(1)) push = 1'b1;
  end

  for (genvar k = 0; k < NODE_COUNT; k++) begin : g_cell
    lots_cell #(.NODE_COUNT(NODE_COUNT)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .set_i     (set_en && (32'(prev_q) == k)),
      .set_col_i (set_col),
      .row_i     (rows_w[(k + 1) % NODE_COUNT]),
      .inc_i     ((state_q == StCount) && rows_w[0][k]),
      .dec_i     (dec_vec[k]),
      .row_o     (rows_w[k]),
      .deg_o     (deg_w[k])
    );
  end

  // Ready queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem[tail_q[IW-1:0]] <= push_idx;
    if (state_q == StPop) rd_q <= q_mem[head_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // the emit states load the output register themselves
      if (out_valid_q && !out_stall_i && state_q != StEmit && state_q != StEmpty)
        out_valid_q <= 1'b0;
      if (push) tail_q <= tail_q + CW'(1);
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (op_i) begin
              state_q <= StCount;
              cnt_q   <= '0;
              head_q  <= '0;
              tail_q  <= '0;
            end else if (!letter_ok) begin
              prev_valid_q <= 1'b0;
            end else begin
              prev_q       <= letter_i;
              prev_valid_q <= 1'b1;
            end
          end
        end
        StCount: begin
          if (cnt_end) begin
            cnt_q   <= '0;
            state_q <= StSeed;
          end else begin
            cnt_q <= cnt_q + IW'(1);
          end
        end
        StSeed: begin
          if (cnt_end) begin
            cnt_q   <= '0;
            state_q <= (tail_q == '0 && !push) ? StEmpty : StPop;
          end else begin
            cnt_q <= cnt_q + IW'(1);
          end
        end
        StPop: begin
          head_q  <= head_q + CW'(1);
          cnt_q   <= '0;
          state_q <= StScan;
        end
        StScan: begin
          cnt_q <= cnt_q + IW'(1);
          if (cnt_end) state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            node_q       <= LetterW'(rd_q);
            node_valid_q <= 1'b1;
            last_q       <= (head_q == tail_q);
            acyclic_q    <= (head_q == tail_q) && (head_q == CW'(NODE_COUNT));
            if (head_q == tail_q) begin
              prev_valid_q <= 1'b0;
              state_q      <= StIdle;
            end else begin
              state_q <= StPop;
            end
          end
        end
        StEmpty: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            node_q       <= '0;
            node_valid_q <= 1'b0;
            last_q       <= 1'b1;
            acyclic_q    <= 1'b0;
            prev_valid_q <= 1'b0;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_o       = node_q;
  assign node_valid_o = node_valid_q;
  assign last_o       = last_q;
  assign acyclic_o    = acyclic_q;

endmodule

### verif/letter_order_topological_sort_core_tb.sv
// Self-checking testbench for the letter-order topological sort core.
`timescale 1ns / 1ps

module letter_order_topological_sort_core_tb;
  import lots_pkg::*;

  localparam int unsigned Nodes = NodeCountDef;
  localparam bit OpLetter = 1'b0;
  localparam bit OpFinish = 1'b1;

  typedef struct packed {
    logic [LetterW-1:0] node;
    logic               node_valid;
    logic               last;
    logic               acyclic;
  } order_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               op_i = 1'b0;
  logic [LetterW-1:0] letter_i = '0;
  logic               starts_word_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LetterW-1:0] node_o;
  logic               node_valid_o;
  logic               last_o;
  logic               acyclic_o;

  // predictor state
  logic [Nodes-1:0]   edge_rows [Nodes];
  logic [LetterW-1:0] prev_letter;
  bit                 prev_valid;
  order_word_t        order_expected [$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  orders_run = 0;
  int  nodes_seen = 0;
  int  rx_hold = 0;
  bit  calm = 1'b0;

  letter_order_topological_sort_core DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("letter_order_topological_sort_core verification failed");
    $finish;
  end

  // output stall: random, long hold-offs on request
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk_i) begin
    order_word_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{node_o, node_valid_o, last_o, acyclic_o};
      nodes_seen++;
      if (order_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected order word %p", got);
      end else begin
        want = order_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("order word mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic void predict_order();
    int indeg [Nodes];
    int ready [Nodes];
    int head = 0;
    int tail = 0;
    int v;
    order_word_t run [$];
    order_word_t w;
    for (int j = 0; j < Nodes; j++) begin
      indeg[j] = 0;
      for (int i = 0; i < Nodes; i++) if (edge_rows[i][j]) indeg[j]++;
    end
    for (int i = 0; i < Nodes; i++) if (indeg[i] == 0) ready[tail++] = i;
    while (head < tail) begin
      v = ready[head++];
      w = '{v[LetterW-1:0], 1'b1, 1'b0, 1'b0};
      run = {run, w};
      for (int j = 0; j < Nodes; j++) begin
        if (edge_rows[v][j]) begin
          indeg[j]--;
          if (indeg[j] == 0) ready[tail++] = j;
        end
      end
    end
    if (run.size() == 0) begin
      w = '{'0, 1'b0, 1'b1, 1'b0};
      run = {run, w};
    end else begin
      run[run.size()-1].last = 1'b1;
      run[run.size()-1].acyclic = (run.size() == Nodes);
    end
    order_expected = {order_expected, run};
    foreach (edge_rows[i]) edge_rows[i] = '0;
    prev_valid = 1'b0;
    orders_run++;
  endfunction

  function automatic void predict_word(bit op, logic [LetterW-1:0] l, bit sw);
    if (op == OpFinish) begin
      predict_order();
    end else if (l >= Nodes) begin
      prev_valid = 1'b0;   // out-of-range letter breaks the word
    end else begin
      if (!sw && prev_valid && prev_letter != l) edge_rows[prev_letter][l] = 1'b1;
      prev_letter = l;
      prev_valid = 1'b1;
    end
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(bit op, logic [LetterW-1:0] l, bit sw);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    letter_i      <= l;
    starts_word_i <= sw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(op, l, sw);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_word(OpLetter, LetterW'(s[k] - "a"), k == 0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (order_expected.size() == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_word(OpFinish, 5'd31, 1'b1);             // empty graph: all nodes in order
    send_text("ba");
    send_text("zyx");
    send_word(OpLetter, 5'd0, 1'b0);              // continues word: x -> a
    send_word(OpLetter, 5'd0, 1'b0);              // repeated letter
    send_word(OpLetter, 5'd31, 1'b0);             // out of range: word break
    send_word(OpLetter, 5'd1, 1'b0);
    send_word(OpLetter, 5'd26, 1'b1);
    send_word(OpLetter, 5'd25, 1'b0);
    send_word(OpFinish, 5'd0, 1'b0);
    send_text("ab");
    send_text("ba");                              // two-node cycle
    send_word(OpFinish, 5'd17, 1'b1);
    drain();
  endtask

  task automatic test_full_chains();
    // one word through every letter and back to a: nothing orderable
    for (int k = 0; k <= Nodes; k++) send_word(OpLetter, LetterW'(k % Nodes), k == 0);
    send_word(OpFinish, 5'd0, 1'b0);
    // reverse chain: fully ordered from z down to a
    for (int k = Nodes - 1; k >= 0; k--) send_word(OpLetter, LetterW'(k), k == Nodes - 1);
    send_word(OpFinish, 5'd0, 1'b0);
    drain();
  endtask

  task automatic test_random_words(int count);
    int n = 0;
    int wlen;
    while (n < count) begin
      wlen = $urandom_range(1, 5);
      for (int k = 0; k < wlen; k++) begin
        if ($urandom_range(99) < 8)
          send_word(OpLetter, LetterW'($urandom_range(26, 31)), 1'($urandom_range(1)));
        else
          send_word(OpLetter, LetterW'($urandom_range(0, 9 + 16 * (n % 2))), k == 0);
        n++;
      end
      if ($urandom_range(99) < 22) begin
        send_word(OpFinish, LetterW'($urandom_range(31)), 1'($urandom_range(1)));
        n++;
      end
    end
    send_word(OpFinish, 5'd0, 1'b0);
  endtask

  task automatic test_output_hold();
    rx_hold = 400;
    send_text("dcba");
    send_word(OpFinish, 5'd0, 1'b0);
    send_text("mnm");
    send_word(OpFinish, 5'd0, 1'b0);
    send_text("qr");
    drain();
  endtask

  initial begin
    foreach (edge_rows[i]) edge_rows[i] = '0;
    prev_letter = '0;
    prev_valid  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_chains();
    test_output_hold();
    calm = 1'b1;
    test_random_words(50);
    calm = 1'b0;
    test_random_words(90);
    drain();
    in_valid_i <= 1'b0;
    repeat (100) @(negedge clk_i);
    $display("covered %0d input words, %0d sort runs, %0d order words checked",
             words_sent, orders_run, nodes_seen);
    if (mismatches == 0 && order_expected.size() == 0) begin
      $display("letter_order_topological_sort_core verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("letter_order_topological_sort_core verification failed");
    end
    $finish;
  end

endmodule
